// ===== sv/pogs_pkg.sv =====
// Package for the predicted obstacle grid stamper.
// Holds sizes, codes, word types and the sequencer state type.
// Depends on nothing; the top level uses it by scoped names.
package pogs_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_LAYERS = 16;
  localparam int BOX_HALF   = 5;
  localparam int STAMP_VAL  = 100;

  localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int LAYER_W = $clog2(MAX_LAYERS);
  localparam int LCNT_W  = $clog2(MAX_LAYERS + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam logic [63:0] THRESH_SQ = 64'(100000000) << 32;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_PERSON  = 2'd1,
    MODE_REFRESH = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_CPM       = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_HEIGHT    = 3'd4,
    CFG_MAP_COUNT = 3'd5,
    CFG_TIME_STEP = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [13:0]        cell_index;
    logic signed [7:0]  cell_value;
    logic [3:0]         layer_select;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               last_person;
  } in_t;

  typedef struct packed {
    logic signed [7:0] read_value;
    logic              stamp_done;
    logic              person_found;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_DSQ_X,
    ST_DSQ_Y,
    ST_DSQ_CMP,
    ST_STEP_X,
    ST_STEP_Y,
    ST_LAYER_INIT,
    ST_CA,
    ST_CHI,
    ST_CLO,
    ST_CFIN,
    ST_BOX,
    ST_SRD,
    ST_SWR,
    ST_CRD,
    ST_CWR,
    ST_POST
  } st_e;

endpackage

// ===== sv/pogs_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
// No dependencies; contents are undefined until written.
module pogs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pogs_mul.sv =====
// Shared 32 by 32 unsigned multiplier with a registered product.
// No dependencies; used by the stamper sequencer for its 32-bit products.
module pogs_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== sv/predicted_obstacle_grid_stamper.sv =====
// Predicted obstacle grid stamper top level: sequencer, tracker and grid memories.
// Depends on pogs_pkg, pogs_ram and pogs_mul.
//
// One word is taken at a time. A layer read and the last person report of a batch wait
// for the output slot. The last report, when a person was found, stamps every used
// layer in up to 121 cells; every stamped cell is a read-modify-write through the single
// read and single write port of the layer memory. A refresh copies every base cell into
// each used layer, 16384 cells in all, bounded by the one write port of the layer memory.
// Both memories come out of reset undefined; no clearing pass is run.
module predicted_obstacle_grid_stamper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pogs_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pogs_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_wdata_i
);

  localparam int C_W = 58;
  localparam int D_W = 56;
  localparam logic signed [C_W-1:0] BOXH = C_W'(pogs_pkg::BOX_HALF);
  localparam logic [pogs_pkg::CELL_W-1:0] LAST_CELL = pogs_pkg::CELL_W'(pogs_pkg::CELLS - 1);

  pogs_pkg::st_e state_q, state_d;

  logic signed [31:0] org_x_q, org_y_q;
  logic [31:0] cpm_q, ts_q;
  logic [7:0]  gw_q, gh_q;
  logic [4:0]  mc_q;

  logic [63:0] best_dsq_q, best_dsq_d;
  logic signed [31:0] bpx_q, bpx_d, bpy_q, bpy_d, bvx_q, bvx_d, bvy_q, bvy_d;
  logic have_best_q, have_best_d;

  pogs_pkg::in_t item_q, item_d;
  logic [63:0] acc_q, acc_d, hip_q, hip_d;
  logic [47:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [51:0] disp_x_q, disp_x_d, disp_y_q, disp_y_d;
  logic axis_q, axis_d, neg_q, neg_d, rd_ok_q, rd_ok_d;
  logic [D_W-1:0] a_q, a_d;
  logic signed [C_W-1:0] ci_q, ci_d, cj_q, cj_d;
  logic [pogs_pkg::LAYER_W-1:0] k_q, k_d;
  logic [pogs_pkg::COL_W-1:0] i_q, i_d, i0_q, i0_d, i1_q, i1_d;
  logic [pogs_pkg::ROW_W-1:0] j_q, j_d, j1_q, j1_d;
  logic [pogs_pkg::CELL_W-1:0] row_q, row_d, c_q, c_d;
  pogs_pkg::out_t res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic accept;
  logic [7:0] used_w, used_h;
  logic [4:0] used_n;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] dsq;
  logic upd, hb_new, last_layer, box_empty, cell_low, slot_free;
  logic [31:0] pxm, pym;
  logic signed [31:0] pos_sel, org_sel;
  logic vneg;
  logic [51:0] disp_sel;
  logic signed [D_W-1:0] p_ax, d_ax;
  logic [63:0] c_full;
  logic signed [C_W-1:0] c_val, wlim, hlim;
  logic signed [C_W-1:0] ilo, ihi, jlo, jhi, ilo_c, ihi_c, jlo_c, jhi_c;
  logic [14:0] row_init;

  logic base_we, base_re;
  logic [7:0] base_rdata;
  logic lay_we, lay_re;
  logic [pogs_pkg::LAYER_W+pogs_pkg::CELL_W-1:0] lay_waddr, lay_raddr;
  logic [7:0] lay_wdata, lay_rdata;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == pogs_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign used_w = (gw_q == 8'd0) ? 8'd1 :
                  (gw_q > 8'(pogs_pkg::MAX_WIDTH)) ? 8'(pogs_pkg::MAX_WIDTH) : gw_q;
  assign used_h = (gh_q == 8'd0) ? 8'd1 :
                  (gh_q > 8'(pogs_pkg::MAX_HEIGHT)) ? 8'(pogs_pkg::MAX_HEIGHT) : gh_q;
  assign used_n = (mc_q > 5'(pogs_pkg::MAX_LAYERS)) ? 5'(pogs_pkg::MAX_LAYERS) : mc_q;

  assign pxm = item_q.pos_x[31] ? (~item_q.pos_x + 32'd1) : item_q.pos_x;
  assign pym = item_q.pos_y[31] ? (~item_q.pos_y + 32'd1) : item_q.pos_y;

  assign dsq    = acc_q + mul_p;
  assign upd    = dsq < best_dsq_q;
  assign hb_new = have_best_q || upd;

  assign pos_sel  = axis_q ? bpy_q : bpx_q;
  assign org_sel  = axis_q ? org_y_q : org_x_q;
  assign vneg     = axis_q ? bvy_q[31] : bvx_q[31];
  assign disp_sel = axis_q ? disp_y_q : disp_x_q;
  assign p_ax = D_W'(pos_sel) + (vneg ? -$signed(D_W'(disp_sel)) : $signed(D_W'(disp_sel)));
  assign d_ax = p_ax - D_W'(org_sel);

  assign c_full = hip_q + ((mul_p + 64'h8000_0000) >> 32);
  assign c_val  = neg_q ? -$signed(c_full[C_W-1:0]) : $signed(c_full[C_W-1:0]);

  assign wlim  = $signed(C_W'(used_w - 8'd1));
  assign hlim  = $signed(C_W'(used_h - 8'd1));
  assign ilo   = ci_q - BOXH;
  assign ihi   = ci_q + BOXH;
  assign jlo   = cj_q - BOXH;
  assign jhi   = cj_q + BOXH;
  assign ilo_c = (ilo < 0) ? '0 : ilo;
  assign ihi_c = (ihi > wlim) ? wlim : ihi;
  assign jlo_c = (jlo < 0) ? '0 : jlo;
  assign jhi_c = (jhi > hlim) ? hlim : jhi;
  assign box_empty = (ilo_c > ihi_c) || (jlo_c > jhi_c);
  assign row_init  = 15'(used_w) * 15'(jlo_c[pogs_pkg::ROW_W-1:0]);

  assign last_layer = ({1'b0, k_q} == (used_n - 5'd1));
  assign cell_low   = $signed(lay_rdata) < 8'sd100;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pogs_pkg::ST_DSQ_X: begin
        mul_a = pxm;
        mul_b = pxm;
      end
      pogs_pkg::ST_DSQ_Y: begin
        mul_a = pym;
        mul_b = pym;
      end
      pogs_pkg::ST_STEP_X: begin
        mul_a = bvx_q[31] ? (~bvx_q + 32'd1) : bvx_q;
        mul_b = ts_q;
      end
      pogs_pkg::ST_STEP_Y: begin
        mul_a = bvy_q[31] ? (~bvy_q + 32'd1) : bvy_q;
        mul_b = ts_q;
      end
      pogs_pkg::ST_CHI: begin
        mul_a = 32'(a_q[D_W-1:32]);
        mul_b = cpm_q;
      end
      pogs_pkg::ST_CLO: begin
        mul_a = a_q[31:0];
        mul_b = cpm_q;
      end
      default: begin
      end
    endcase
  end

  pogs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign base_we = accept && (in_data_i.mode == pogs_pkg::MODE_LOAD);
  assign base_re = (state_q == pogs_pkg::ST_CRD);

  pogs_ram #(
    .WIDTH (8),
    .DEPTH (pogs_pkg::CELLS)
  ) u_base (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (in_data_i.cell_index),
    .wdata_i (in_data_i.cell_value),
    .re_i    (base_re),
    .raddr_i (c_q),
    .rdata_o (base_rdata)
  );

  always_comb begin
    lay_we    = 1'b0;
    lay_waddr = {k_q, c_q};
    lay_wdata = base_rdata;
    lay_re    = 1'b0;
    lay_raddr = {k_q, row_q + pogs_pkg::CELL_W'(i_q)};
    if (state_q == pogs_pkg::ST_CWR) begin
      lay_we = 1'b1;
    end else if (state_q == pogs_pkg::ST_SWR) begin
      lay_we    = cell_low;
      lay_waddr = {k_q, row_q + pogs_pkg::CELL_W'(i_q)};
      lay_wdata = 8'(pogs_pkg::STAMP_VAL);
    end
    if (state_q == pogs_pkg::ST_SRD) begin
      lay_re = 1'b1;
    end else if (accept && in_data_i.mode == pogs_pkg::MODE_READ) begin
      lay_re    = 1'b1;
      lay_raddr = {in_data_i.layer_select, in_data_i.cell_index};
    end
  end

  pogs_ram #(
    .WIDTH (8),
    .DEPTH (pogs_pkg::MAX_LAYERS * pogs_pkg::CELLS)
  ) u_layer (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (lay_waddr),
    .wdata_i (lay_wdata),
    .re_i    (lay_re),
    .raddr_i (lay_raddr),
    .rdata_o (lay_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pogs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.mode)
            pogs_pkg::MODE_LOAD:    state_d = pogs_pkg::ST_IDLE;
            pogs_pkg::MODE_PERSON:  state_d = pogs_pkg::ST_DSQ_X;
            pogs_pkg::MODE_REFRESH: state_d = (used_n == 5'd0) ? pogs_pkg::ST_IDLE
                                                               : pogs_pkg::ST_CRD;
            pogs_pkg::MODE_READ:    state_d = pogs_pkg::ST_RDWAIT;
            default:                state_d = pogs_pkg::ST_IDLE;
          endcase
        end
      end
      pogs_pkg::ST_RDWAIT:  state_d = pogs_pkg::ST_POST;
      pogs_pkg::ST_DSQ_X:   state_d = pogs_pkg::ST_DSQ_Y;
      pogs_pkg::ST_DSQ_Y:   state_d = pogs_pkg::ST_DSQ_CMP;
      pogs_pkg::ST_DSQ_CMP: begin
        if (!item_q.last_person) begin
          state_d = pogs_pkg::ST_IDLE;
        end else if (hb_new) begin
          state_d = pogs_pkg::ST_STEP_X;
        end else begin
          state_d = pogs_pkg::ST_POST;
        end
      end
      pogs_pkg::ST_STEP_X:     state_d = pogs_pkg::ST_STEP_Y;
      pogs_pkg::ST_STEP_Y:     state_d = pogs_pkg::ST_LAYER_INIT;
      pogs_pkg::ST_LAYER_INIT: state_d = (used_n == 5'd0) ? pogs_pkg::ST_POST
                                                          : pogs_pkg::ST_CA;
      pogs_pkg::ST_CA:   state_d = pogs_pkg::ST_CHI;
      pogs_pkg::ST_CHI:  state_d = pogs_pkg::ST_CLO;
      pogs_pkg::ST_CLO:  state_d = pogs_pkg::ST_CFIN;
      pogs_pkg::ST_CFIN: state_d = axis_q ? pogs_pkg::ST_BOX : pogs_pkg::ST_CA;
      pogs_pkg::ST_BOX: begin
        if (!box_empty) begin
          state_d = pogs_pkg::ST_SRD;
        end else if (last_layer) begin
          state_d = pogs_pkg::ST_POST;
        end else begin
          state_d = pogs_pkg::ST_CA;
        end
      end
      pogs_pkg::ST_SRD: state_d = pogs_pkg::ST_SWR;
      pogs_pkg::ST_SWR: begin
        if (i_q == i1_q && j_q == j1_q) begin
          state_d = last_layer ? pogs_pkg::ST_POST : pogs_pkg::ST_CA;
        end else begin
          state_d = pogs_pkg::ST_SRD;
        end
      end
      pogs_pkg::ST_CRD: state_d = pogs_pkg::ST_CWR;
      pogs_pkg::ST_CWR: begin
        if (last_layer) begin
          state_d = (c_q == LAST_CELL) ? pogs_pkg::ST_IDLE : pogs_pkg::ST_CRD;
        end
      end
      pogs_pkg::ST_POST: begin
        if (slot_free) begin
          state_d = pogs_pkg::ST_IDLE;
        end
      end
      default: state_d = pogs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    best_dsq_d  = best_dsq_q;
    bpx_d       = bpx_q;
    bpy_d       = bpy_q;
    bvx_d       = bvx_q;
    bvy_d       = bvy_q;
    have_best_d = have_best_q;
    item_d      = item_q;
    acc_d       = acc_q;
    hip_d       = hip_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    disp_x_d    = disp_x_q;
    disp_y_d    = disp_y_q;
    axis_d      = axis_q;
    neg_d       = neg_q;
    rd_ok_d     = rd_ok_q;
    a_d         = a_q;
    ci_d        = ci_q;
    cj_d        = cj_q;
    k_d         = k_q;
    i_d         = i_q;
    i0_d        = i0_q;
    i1_d        = i1_q;
    j_d         = j_q;
    j1_d        = j1_q;
    row_d       = row_q;
    c_d         = c_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pogs_pkg::ST_IDLE: begin
        if (accept) begin
          item_d  = in_data_i;
          rd_ok_d = ({1'b0, in_data_i.layer_select} < used_n);
          c_d     = '0;
          k_d     = '0;
        end
      end
      pogs_pkg::ST_RDWAIT: begin
        res_d.read_value   = rd_ok_q ? lay_rdata : -8'sd1;
        res_d.stamp_done   = 1'b0;
        res_d.person_found = 1'b0;
      end
      pogs_pkg::ST_DSQ_Y: begin
        acc_d = mul_p;
      end
      pogs_pkg::ST_DSQ_CMP: begin
        if (upd) begin
          best_dsq_d  = dsq;
          bpx_d       = item_q.pos_x;
          bpy_d       = item_q.pos_y;
          bvx_d       = item_q.vel_x;
          bvy_d       = item_q.vel_y;
          have_best_d = 1'b1;
        end
        res_d.read_value   = '0;
        res_d.stamp_done   = 1'b1;
        res_d.person_found = hb_new;
        if (item_q.last_person && !hb_new) begin
          best_dsq_d  = pogs_pkg::THRESH_SQ;
          bpx_d       = '0;
          bpy_d       = '0;
          bvx_d       = '0;
          bvy_d       = '0;
          have_best_d = 1'b0;
        end
      end
      pogs_pkg::ST_STEP_Y: begin
        step_x_d = 48'((mul_p + 64'd32768) >> 16);
      end
      pogs_pkg::ST_LAYER_INIT: begin
        step_y_d = 48'((mul_p + 64'd32768) >> 16);
        disp_x_d = '0;
        disp_y_d = '0;
        k_d      = '0;
        axis_d   = 1'b0;
      end
      pogs_pkg::ST_CA: begin
        neg_d = d_ax[D_W-1];
        a_d   = d_ax[D_W-1] ? D_W'(-d_ax) : D_W'(d_ax);
      end
      pogs_pkg::ST_CLO: begin
        hip_d = mul_p;
      end
      pogs_pkg::ST_CFIN: begin
        if (axis_q) begin
          cj_d = c_val;
        end else begin
          ci_d = c_val;
        end
        axis_d = !axis_q;
      end
      pogs_pkg::ST_BOX: begin
        i_d   = ilo_c[pogs_pkg::COL_W-1:0];
        i0_d  = ilo_c[pogs_pkg::COL_W-1:0];
        i1_d  = ihi_c[pogs_pkg::COL_W-1:0];
        j_d   = jlo_c[pogs_pkg::ROW_W-1:0];
        j1_d  = jhi_c[pogs_pkg::ROW_W-1:0];
        row_d = row_init[pogs_pkg::CELL_W-1:0];
        if (box_empty) begin
          k_d      = k_q + 1'b1;
          disp_x_d = disp_x_q + 52'(step_x_q);
          disp_y_d = disp_y_q + 52'(step_y_q);
        end
      end
      pogs_pkg::ST_SWR: begin
        if (i_q == i1_q) begin
          i_d = i0_q;
          if (j_q == j1_q) begin
            k_d      = k_q + 1'b1;
            disp_x_d = disp_x_q + 52'(step_x_q);
            disp_y_d = disp_y_q + 52'(step_y_q);
          end else begin
            j_d   = j_q + 1'b1;
            row_d = row_q + pogs_pkg::CELL_W'(used_w);
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      pogs_pkg::ST_CWR: begin
        if (last_layer) begin
          k_d = '0;
          c_d = c_q + 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      pogs_pkg::ST_POST: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if ((state_q == pogs_pkg::ST_BOX && box_empty && last_layer) ||
        (state_q == pogs_pkg::ST_SWR && i_q == i1_q && j_q == j1_q && last_layer) ||
        (state_q == pogs_pkg::ST_LAYER_INIT && used_n == 5'd0)) begin
      best_dsq_d  = pogs_pkg::THRESH_SQ;
      bpx_d       = '0;
      bpy_d       = '0;
      bvx_d       = '0;
      bvy_d       = '0;
      have_best_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pogs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      cpm_q       <= 32'd1310720;
      gw_q        <= 8'd128;
      gh_q        <= 8'd128;
      mc_q        <= 5'd10;
      ts_q        <= 32'd32768;
      best_dsq_q  <= pogs_pkg::THRESH_SQ;
      bpx_q       <= '0;
      bpy_q       <= '0;
      bvx_q       <= '0;
      bvy_q       <= '0;
      have_best_q <= 1'b0;
      k_q         <= '0;
      c_q         <= '0;
      axis_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      best_dsq_q  <= best_dsq_d;
      bpx_q       <= bpx_d;
      bpy_q       <= bpy_d;
      bvx_q       <= bvx_d;
      bvy_q       <= bvy_d;
      have_best_q <= have_best_d;
      k_q         <= k_d;
      c_q         <= c_d;
      axis_q      <= axis_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pogs_pkg::CFG_ORIGIN_X:  org_x_q <= cfg_wdata_i;
          pogs_pkg::CFG_ORIGIN_Y:  org_y_q <= cfg_wdata_i;
          pogs_pkg::CFG_CPM:       cpm_q   <= cfg_wdata_i;
          pogs_pkg::CFG_WIDTH:     gw_q    <= cfg_wdata_i[7:0];
          pogs_pkg::CFG_HEIGHT:    gh_q    <= cfg_wdata_i[7:0];
          pogs_pkg::CFG_MAP_COUNT: mc_q    <= cfg_wdata_i[4:0];
          pogs_pkg::CFG_TIME_STEP: ts_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    acc_q    <= acc_d;
    hip_q    <= hip_d;
    step_x_q <= step_x_d;
    step_y_q <= step_y_d;
    disp_x_q <= disp_x_d;
    disp_y_q <= disp_y_d;
    neg_q    <= neg_d;
    rd_ok_q  <= rd_ok_d;
    a_q      <= a_d;
    ci_q     <= ci_d;
    cj_q     <= cj_d;
    i_q      <= i_d;
    i0_q     <= i0_d;
    i1_q     <= i1_d;
    j_q      <= j_d;
    j1_q     <= j1_d;
    row_q    <= row_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  a_no_layer_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pogs_pkg::ST_IDLE) |-> !lay_we)
    else $error("layer memory written while idle");

  a_stamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pogs_pkg::ST_SWR && lay_we) |-> (lay_wdata == 8'(pogs_pkg::STAMP_VAL)))
    else $error("stamp wrote a value other than the occupied mark");

  a_result_from_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == pogs_pkg::ST_POST))
    else $error("result word raised outside the post state");

endmodule
